### rtl/rrv_pkg.sv
// ============================================================================
// rrv_pkg: shared constants and types for the random vector rotation block
// Fixed-point formats, CORDIC angle table and the matrix bundle type.
// ============================================================================
package rrv_pkg;

    // Default parameter values
    localparam int DATA_WIDTH_DEF  = 24;
    localparam int ANGLE_WIDTH_DEF = 16;

    // Fixed field and internal widths
    localparam int MIX_W  = 16;   // pole mix, unsigned fraction
    localparam int TRIG_W = 32;   // sine / cosine, Q2.30
    localparam int ROOT_W = 30;   // sqrt(u(1-u)), Q30
    localparam int H_W    = 34;   // Householder entries, Q30 with headroom
    localparam int M_W    = 17;   // rotation matrix entries, Q15 in [-1,1]

    // CORDIC schedule: two micro-rotations per pipeline stage
    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_STAGES = CORDIC_STEPS / 2;

    // Arctangents of 2^-i in 32-bit turn units
    localparam logic signed [31:0] TURN_ATAN [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    // Nine Q15 matrix entries, row major, entry 0 in the low slot
    typedef logic [8:0][M_W-1:0] mat_t;

endpackage

### rtl/rrv_sincos.sv
// ============================================================================
// rrv_sincos: pipelined CORDIC sine and cosine of a turn fraction
// Eight stages of two micro-rotations each, quadrant fold on the output.
// ============================================================================
module rrv_sincos
    import rrv_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vld_i,
    input  logic [ANGLE_WIDTH-1:0]   turn,
    output logic                     vld_o,
    output logic signed [TRIG_W-1:0] cos_o,
    output logic signed [TRIG_W-1:0] sin_o
);

    localparam int CW = 34;
    localparam int ZW = 32;
    localparam logic signed [CW-1:0] GAIN = 34'sd652032874;

    logic signed [CW-1:0] x_reg  [CORDIC_STAGES];
    logic signed [CW-1:0] y_reg  [CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg  [CORDIC_STAGES];
    logic [1:0]           q_reg  [CORDIC_STAGES];
    logic signed [CW-1:0] x_next [CORDIC_STAGES];
    logic signed [CW-1:0] y_next [CORDIC_STAGES];
    logic signed [ZW-1:0] z_next [CORDIC_STAGES];
    logic [1:0]           q_next [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] vld_reg;
    logic [CORDIC_STAGES-1:0] vld_next;

    // Micro-rotations for every stage
    always_comb
    begin
        logic signed [CW-1:0] x, y, dx, dy;
        logic signed [ZW-1:0] z;
        logic [1:0]           q;
        logic [31:0]          phase;
        int                   i;
        phase = 32'(64'(turn) << (32 - ANGLE_WIDTH));
        for (int st = 0; st < CORDIC_STAGES; st++)
        begin
            if (st == 0)
            begin
                x = GAIN;
                y = '0;
                z = $signed({2'b00, phase[29:0]});
                q = phase[31:30];
                vld_next[st] = vld_i;
            end
            else
            begin
                x = x_reg[st-1];
                y = y_reg[st-1];
                z = z_reg[st-1];
                q = q_reg[st-1];
                vld_next[st] = vld_reg[st-1];
            end
            for (int j = 0; j < 2; j++)
            begin
                i  = 2 * st + j;
                dx = y >>> i;
                dy = x >>> i;
                if (!z[ZW-1])
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - TURN_ATAN[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + TURN_ATAN[i];
                end
            end
            x_next[st] = x;
            y_next[st] = y;
            z_next[st] = z;
            q_next[st] = q;
        end
    end

    // Stage registers: valid bits reset, payload free running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int st = 0; st < CORDIC_STAGES; st++)
        begin
            x_reg[st] <= x_next[st];
            y_reg[st] <= y_next[st];
            z_reg[st] <= z_next[st];
            q_reg[st] <= q_next[st];
        end
    end

    // Quadrant fold
    always_comb
    begin
        logic signed [CW-1:0] xl, yl;
        xl = x_reg[CORDIC_STAGES-1];
        yl = y_reg[CORDIC_STAGES-1];
        case (q_reg[CORDIC_STAGES-1])
            2'd0:
            begin
                cos_o = TRIG_W'(xl);
                sin_o = TRIG_W'(yl);
            end
            2'd1:
            begin
                cos_o = TRIG_W'(-yl);
                sin_o = TRIG_W'(xl);
            end
            2'd2:
            begin
                cos_o = TRIG_W'(-xl);
                sin_o = TRIG_W'(-yl);
            end
            default:
            begin
                cos_o = TRIG_W'(yl);
                sin_o = TRIG_W'(-xl);
            end
        endcase
    end

    assign vld_o = vld_reg[CORDIC_STAGES-1];

endmodule

### rtl/rrv_root.sv
// ============================================================================
// rrv_root: pipelined bitwise square root of u(1-u)
// Two result bits in the first stage, four in each of the seven others.
// ============================================================================
module rrv_root
    import rrv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vld_i,
    input  logic [MIX_W-1:0] mix,
    output logic             vld_o,
    output logic [ROOT_W-1:0] w_o,
    output logic [MIX_W-1:0] mix_o
);

    localparam int NSTG = CORDIC_STAGES;
    localparam int RW   = 61;
    localparam int FIRST_STEPS = 2;
    localparam int STEPS = 4;

    logic [RW-1:0]     rem_reg  [NSTG];
    logic [ROOT_W-1:0] r_reg    [NSTG];
    logic [MIX_W-1:0]  mix_reg  [NSTG];
    logic [RW-1:0]     rem_next [NSTG];
    logic [ROOT_W-1:0] r_next   [NSTG];
    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   vld_next;

    // Restoring root steps, bit index counts down from the top
    always_comb
    begin
        logic [RW-1:0]     rem, trial;
        logic [ROOT_W-1:0] r;
        logic [33:0]       prod;
        int                k, bi;
        prod = 34'(mix) * (34'd65536 - 34'(mix));
        for (int st = 0; st < NSTG; st++)
        begin
            if (st == 0)
            begin
                rem = RW'(prod) << 28;
                r   = '0;
                vld_next[st] = vld_i;
            end
            else
            begin
                rem = rem_reg[st-1];
                r   = r_reg[st-1];
                vld_next[st] = vld_reg[st-1];
            end
            for (int j = 0; j < STEPS; j++)
            begin
                k  = (st == 0) ? j : FIRST_STEPS + (st - 1) * STEPS + j;
                bi = ROOT_W - 1 - k;
                if ((st != 0 || j < FIRST_STEPS) && bi >= 0)
                begin
                    trial = (RW'(r) << (bi + 1)) | (RW'(1) << (2 * bi));
                    if (rem >= trial)
                    begin
                        rem = rem - trial;
                        r   = r | (ROOT_W'(1) << bi);
                    end
                end
            end
            rem_next[st] = rem;
            r_next[st]   = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int st = 0; st < NSTG; st++)
        begin
            rem_reg[st] <= rem_next[st];
            r_reg[st]   <= r_next[st];
            mix_reg[st] <= (st == 0) ? mix : mix_reg[(st == 0) ? 0 : st - 1];
        end
    end

    assign vld_o = vld_reg[NSTG-1];
    assign w_o   = r_reg[NSTG-1];
    assign mix_o = mix_reg[NSTG-1];

endmodule

### rtl/rrv_matrix.sv
// ============================================================================
// rrv_matrix: builds the Q15 rotation matrix from sines, cosines and root
// Four stages: squares, Householder entries, products, rounded sums.
// ============================================================================
module rrv_matrix
    import rrv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vld_i,
    input  logic signed [TRIG_W-1:0] cos_a,
    input  logic signed [TRIG_W-1:0] sin_a,
    input  logic signed [TRIG_W-1:0] cos_b,
    input  logic signed [TRIG_W-1:0] sin_b,
    input  logic [ROOT_W-1:0]        w,
    input  logic [MIX_W-1:0]         mix,
    output logic                     vld_o,
    output mat_t                     mat
);

    localparam int PW = H_W + TRIG_W;
    localparam int SW = 68;

    // Product slots of the third stage
    localparam int P11C = 0, P11S = 1, P12C = 2, P12S = 3, P22C = 4;
    localparam int P22S = 5, P13C = 6, P13S = 7, P23C = 8, P23S = 9;

    logic [3:0] vld_reg;

    // -round(v / 2^45) clamped to [-1, 1] in Q15
    function automatic logic [M_W-1:0] q15_of(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] sh, ng;
        logic [M_W-1:0]       res;
        sh = (v + (68'sd1 <<< 44)) >>> 45;
        ng = -sh;
        if (ng > 68'sd32768)
            res = 17'sd32768;
        else if (ng < -68'sd32768)
            res = -17'sd32768;
        else
            res = M_W'(ng);
        return res;
    endfunction

    // Stage 1: second-angle squares and pole terms
    logic signed [TRIG_W-1:0] tcc_reg, tcs_reg, tss_reg, c1_reg, s1_reg;
    logic signed [H_W-1:0]    h13_reg, h23_reg;
    logic [MIX_W-1:0]         mix_reg;
    logic signed [63:0]       pcc, pcs, pss;
    logic signed [62:0]       pcw, psw;
    logic signed [ROOT_W:0]   ws;

    assign ws  = $signed({1'b0, w});
    assign pcc = cos_b * cos_b;
    assign pcs = cos_b * sin_b;
    assign pss = sin_b * sin_b;
    assign pcw = cos_b * ws;
    assign psw = sin_b * ws;

    always_ff @(posedge clk)
    begin
        tcc_reg <= TRIG_W'((pcc + (64'sd1 <<< 29)) >>> 30);
        tcs_reg <= TRIG_W'((pcs + (64'sd1 <<< 29)) >>> 30);
        tss_reg <= TRIG_W'((pss + (64'sd1 <<< 29)) >>> 30);
        h13_reg <= H_W'(-((pcw + (63'sd1 <<< 28)) >>> 29));
        h23_reg <= H_W'(-((psw + (63'sd1 <<< 28)) >>> 29));
        c1_reg  <= cos_a;
        s1_reg  <= sin_a;
        mix_reg <= mix;
    end

    // Stage 2: Householder entries
    logic signed [H_W-1:0]    h11_reg, h12_reg, h22_reg, h33_reg, h13d_reg, h23d_reg;
    logic signed [TRIG_W-1:0] c1d_reg, s1d_reg;
    logic signed [MIX_W:0]    ps;
    logic signed [48:0]       qcc, qcs, qss;

    assign ps  = $signed({1'b0, mix_reg});
    assign qcc = ps * tcc_reg;
    assign qcs = ps * tcs_reg;
    assign qss = ps * tss_reg;

    always_ff @(posedge clk)
    begin
        h11_reg  <= H_W'((49'sd1 <<< 30) - ((qcc + (49'sd1 <<< 14)) >>> 15));
        h12_reg  <= H_W'(-((qcs + (49'sd1 <<< 14)) >>> 15));
        h22_reg  <= H_W'((49'sd1 <<< 30) - ((qss + (49'sd1 <<< 14)) >>> 15));
        h33_reg  <= H_W'($signed({1'b0, mix_reg, 15'b0})) - (H_W'(1) <<< 30);
        h13d_reg <= h13_reg;
        h23d_reg <= h23_reg;
        c1d_reg  <= c1_reg;
        s1d_reg  <= s1_reg;
    end

    // Stage 3: H times R products, diagonal-free column done directly
    logic signed [PW-1:0] prd_reg [10];
    logic [M_W-1:0]       m2_reg, m5_reg, m8_reg;

    always_ff @(posedge clk)
    begin
        prd_reg[P11C] <= h11_reg * c1d_reg;
        prd_reg[P11S] <= h11_reg * s1d_reg;
        prd_reg[P12C] <= h12_reg * c1d_reg;
        prd_reg[P12S] <= h12_reg * s1d_reg;
        prd_reg[P22C] <= h22_reg * c1d_reg;
        prd_reg[P22S] <= h22_reg * s1d_reg;
        prd_reg[P13C] <= h13d_reg * c1d_reg;
        prd_reg[P13S] <= h13d_reg * s1d_reg;
        prd_reg[P23C] <= h23d_reg * c1d_reg;
        prd_reg[P23S] <= h23d_reg * s1d_reg;
        m2_reg <= q15_of(SW'(h13d_reg) <<< 30);
        m5_reg <= q15_of(SW'(h23d_reg) <<< 30);
        m8_reg <= q15_of(SW'(h33_reg) <<< 30);
    end

    // Stage 4: sums of pairs, rounded and clamped
    mat_t mat_reg;

    always_ff @(posedge clk)
    begin
        mat_reg[0] <= q15_of(SW'(prd_reg[P11C]) - SW'(prd_reg[P12S]));
        mat_reg[1] <= q15_of(SW'(prd_reg[P11S]) + SW'(prd_reg[P12C]));
        mat_reg[2] <= m2_reg;
        mat_reg[3] <= q15_of(SW'(prd_reg[P12C]) - SW'(prd_reg[P22S]));
        mat_reg[4] <= q15_of(SW'(prd_reg[P12S]) + SW'(prd_reg[P22C]));
        mat_reg[5] <= m5_reg;
        mat_reg[6] <= q15_of(SW'(prd_reg[P13C]) - SW'(prd_reg[P23S]));
        mat_reg[7] <= q15_of(SW'(prd_reg[P13S]) + SW'(prd_reg[P23C]));
        mat_reg[8] <= m8_reg;
    end

    // Valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], vld_i};
        end
    end

    assign vld_o = vld_reg[3];
    assign mat   = mat_reg;

endmodule

### rtl/rrv_apply.sv
// ============================================================================
// rrv_apply: multiplies the vector by the Q15 matrix and saturates
// Three stages: nine products, row sums with rounding, saturation.
// ============================================================================
module rrv_apply
    import rrv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         vld_i,
    input  mat_t                         mat,
    input  logic signed [DATA_WIDTH-1:0] vx,
    input  logic signed [DATA_WIDTH-1:0] vy,
    input  logic signed [DATA_WIDTH-1:0] vz,
    output logic                         vld_o,
    output logic signed [DATA_WIDTH-1:0] ox,
    output logic signed [DATA_WIDTH-1:0] oy,
    output logic signed [DATA_WIDTH-1:0] oz,
    output logic                         clip_o
);

    localparam int PW = DATA_WIDTH + M_W;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] MAXV = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    logic [2:0]                  vld_reg;
    logic signed [PW-1:0]        prd_reg [9];
    logic signed [SW-1:0]        sum_reg [3];
    logic signed [DATA_WIDTH-1:0] res_reg [3];
    logic                        clip_reg;
    logic signed [DATA_WIDTH-1:0] vec [3];

    assign vec[0] = vx;
    assign vec[1] = vy;
    assign vec[2] = vz;

    // Stage 1: products
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prd_reg[3*k+j] <= vec[j] * $signed(mat[3*k+j]);
            end
        end
    end

    // Stage 2: row sums rounded half up to the vector scale
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_reg[k] <= (SW'(prd_reg[3*k]) + SW'(prd_reg[3*k+1]) + SW'(prd_reg[3*k+2])
                           + (SW'(1) <<< 14)) >>> 15;
        end
    end

    // Stage 3: saturation
    always_ff @(posedge clk)
    begin
        logic any;
        any = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (sum_reg[k] > MAXV)
            begin
                res_reg[k] <= DATA_WIDTH'(MAXV);
                any = 1'b1;
            end
            else if (sum_reg[k] < MINV)
            begin
                res_reg[k] <= DATA_WIDTH'(MINV);
                any = 1'b1;
            end
            else
            begin
                res_reg[k] <= DATA_WIDTH'(sum_reg[k]);
            end
        end
        clip_reg <= any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], vld_i};
        end
    end

    assign vld_o  = vld_reg[2];
    assign ox     = res_reg[0];
    assign oy     = res_reg[1];
    assign oz     = res_reg[2];
    assign clip_o = clip_reg;

endmodule

### rtl/random_rotation_of_vector.sv
// ============================================================================
// random_rotation_of_vector: applies a random rotation to a 3D vector
// Arvo's rotation from two turn fractions and a pole mix, fully pipelined.
// ============================================================================
// A transaction is taken on every cycle with start high; busy stays low, so
// the block accepts one vector per clock with no gaps. Each result appears on
// out_x/out_y/out_z/clipped for a single cycle with done high. Its path runs
// through the eight-stage CORDIC (two micro-rotations per stage, with the
// square root running alongside), four stages that build the matrix and
// three that apply it. There is no back-pressure: results must be captured
// in the cycle done is high.
module random_rotation_of_vector
    import rrv_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ANGLE_WIDTH-1:0]       turn_a,
    input  logic [ANGLE_WIDTH-1:0]       turn_b,
    input  logic [MIX_W-1:0]             pole_mix,
    input  logic signed [DATA_WIDTH-1:0] in_x,
    input  logic signed [DATA_WIDTH-1:0] in_y,
    input  logic signed [DATA_WIDTH-1:0] in_z,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] out_x,
    output logic signed [DATA_WIDTH-1:0] out_y,
    output logic signed [DATA_WIDTH-1:0] out_z,
    output logic                         clipped
);

    localparam int VDLY = CORDIC_STAGES + 4;
    localparam int LAT  = VDLY + 3;

    logic                     acc;
    logic                     vld_a, vld_b, vld_r, vld_m;
    logic signed [TRIG_W-1:0] c1, s1, c2, s2;
    logic [ROOT_W-1:0]        w;
    logic [MIX_W-1:0]         mix_d;
    mat_t                     mat;

    logic signed [DATA_WIDTH-1:0] vx_reg [VDLY];
    logic signed [DATA_WIDTH-1:0] vy_reg [VDLY];
    logic signed [DATA_WIDTH-1:0] vz_reg [VDLY];

    // The pipeline never stalls
    assign busy = 1'b0;
    assign acc  = start && !busy;

    rrv_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sincos_a
    (
        .clk   (clk),
        .rst_n (rst_n),
        .vld_i (acc),
        .turn  (turn_a),
        .vld_o (vld_a),
        .cos_o (c1),
        .sin_o (s1)
    );

    rrv_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sincos_b
    (
        .clk   (clk),
        .rst_n (rst_n),
        .vld_i (acc),
        .turn  (turn_b),
        .vld_o (vld_b),
        .cos_o (c2),
        .sin_o (s2)
    );

    rrv_root u_root
    (
        .clk   (clk),
        .rst_n (rst_n),
        .vld_i (acc),
        .mix   (pole_mix),
        .vld_o (vld_r),
        .w_o   (w),
        .mix_o (mix_d)
    );

    rrv_matrix u_matrix
    (
        .clk   (clk),
        .rst_n (rst_n),
        .vld_i (vld_a && vld_b && vld_r),
        .cos_a (c1),
        .sin_a (s1),
        .cos_b (c2),
        .sin_b (s2),
        .w     (w),
        .mix   (mix_d),
        .vld_o (vld_m),
        .mat   (mat)
    );

    // Vector delay line to meet the matrix
    always_ff @(posedge clk)
    begin
        vx_reg[0] <= in_x;
        vy_reg[0] <= in_y;
        vz_reg[0] <= in_z;
        for (int i = 1; i < VDLY; i++)
        begin
            vx_reg[i] <= vx_reg[i-1];
            vy_reg[i] <= vy_reg[i-1];
            vz_reg[i] <= vz_reg[i-1];
        end
    end

    rrv_apply #(.DATA_WIDTH(DATA_WIDTH)) u_apply
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld_i  (vld_m),
        .mat    (mat),
        .vx     (vx_reg[VDLY-1]),
        .vy     (vy_reg[VDLY-1]),
        .vz     (vz_reg[VDLY-1]),
        .vld_o  (done),
        .ox     (out_x),
        .oy     (out_y),
        .oz     (out_z),
        .clip_o (clipped)
    );

    // Every accepted transaction yields one result with done high
    a_issue_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##LAT done)
        else $error("accepted transaction produced no result");

    // No result without a matching accepted transaction
    a_done_has_issue: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, LAT))
        else $error("result without matching transaction");

    // The three front-end pipelines stay in lockstep
    a_front_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_a == vld_b) && (vld_a == vld_r))
        else $error("front-end valid bits out of step");

endmodule
